>>> hw/rtl/pli_pkg.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator package
// Widths, request layout, operation and status codes shared by the front end,
// the request queue, the table engine and the multiply-divide unit.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = 7;
    localparam int RADIUS_W    = 32;
    localparam int VALUE_W     = 48;
    localparam int STATUS_W    = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int MAG_W       = VALUE_W + 1;
    localparam int HI_W        = MAG_W - RADIUS_W;
    localparam int PROD_W      = MAG_W + RADIUS_W;
    localparam int DIV_CNT_W   = $clog2(MAG_W);
    localparam int ENTRY_W     = VALUE_W + RADIUS_W;

    // input tdata layout, lowest field first
    localparam int IDX_LSB     = 0;
    localparam int RAD_LSB     = IDX_LSB + IDX_W;
    localparam int VAL_LSB     = RAD_LSB + RADIUS_W;
    localparam int QRY_LSB     = VAL_LSB + VALUE_W;
    localparam int IN_FIELDS_W = QRY_LSB + RADIUS_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((VALUE_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(2);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_NOSEG = 2'd2
    } status_t;

    typedef struct packed {
        op_t                        op;
        logic [IDX_W-1:0]           index;
        logic [RADIUS_W-1:0]        radius;
        logic signed [VALUE_W-1:0]  value;
        logic [RADIUS_W-1:0]        query;
        logic [IDX_W-1:0]           last;
    } req_t;

    typedef struct packed {
        logic [MAG_W-1:0]    mag;
        logic [RADIUS_W-1:0] offset;
        logic [RADIUS_W-1:0] width;
    } md_req_t;

endpackage

>>> hw/rtl/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator
// Breakpoint table of radius/value pairs; writes entries and interpolates a
// query radius over the first enclosing segment.
// ----------------------------------------------------------------------------
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser: op; tdata: index, radius, value, query
// m_*       out  m_tvalid/m_tready  tuser: status; tdata: result_value
// cfg_*     in   cfg_wr_en          cfg_wr_data: entry_count
//
// For a query the table has one read port and is scanned one entry per cycle,
// then a 49-step divider forms the quotient.
// Requests are handled one at a time; a two-entry queue keeps input open while
// a query runs or a result waits.
// Reset clears control state and sets entry_count to 2; table entries are
// undefined until written.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [pli_pkg::COUNT_W-1:0]       cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // entry_index, entry_radius, entry_value, query_radius, zero pad
    input  logic [pli_pkg::IN_DATA_W-1:0]     s_tdata,
    // op
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // result_value
    output logic [pli_pkg::OUT_DATA_W-1:0]    m_tdata,
    // status
    output logic [pli_pkg::STATUS_W-1:0]      m_tuser
);

    logic                        q_push;
    logic                        q_ready;
    pli_pkg::req_t               q_req;
    logic                        q_valid;
    logic                        q_pop;
    pli_pkg::req_t               q_head;
    logic                        md_start;
    pli_pkg::md_req_t            md_req;
    logic                        md_done;
    logic [pli_pkg::MAG_W-1:0]   md_quo;

    pli_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .q_push      (q_push),
        .q_req       (q_req),
        .q_ready     (q_ready)
    );

    pli_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_req (q_req),
        .ready    (q_ready),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    pli_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .req   (md_req),
        .done  (md_done),
        .quo   (md_quo)
    );

    pli_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .md_start (md_start),
        .md_req   (md_req),
        .md_done  (md_done),
        .md_quo   (md_quo),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef NO_ASSERTIONS
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("request popped from empty queue");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |=> !md_done)
        else $error("divider done held for two cycles");

    a_start_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        md_start |=> !md_done)
        else $error("divider done right after start");

    a_pop_result_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!m_tvalid || m_tready))
        else $error("request taken while result register is occupied");
`endif

endmodule

>>> hw/rtl/pli_front.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator front end
// Holds the entry count register, takes input requests, unpacks and
// classifies them and hands them to the request queue.
// ----------------------------------------------------------------------------
module pli_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [pli_pkg::COUNT_W-1:0]       cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pli_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [0:0]                        s_tuser,
    output logic                              q_push,
    output pli_pkg::req_t                     q_req,
    input  logic                              q_ready
);

    logic [pli_pkg::COUNT_W-1:0] count_reg;
    logic                        valid_reg;
    logic                        valid_next;
    pli_pkg::req_t               req_reg;
    pli_pkg::req_t               req_next;
    logic [pli_pkg::IDX_W-1:0]   last_idx;
    logic                        accept;

    // clamp the entry count to between 2 and the table size
    always_comb
    begin
        priority if (count_reg < pli_pkg::COUNT_W'(2))
            last_idx = pli_pkg::IDX_W'(1);
        else if (count_reg > pli_pkg::COUNT_W'(pli_pkg::TABLE_DEPTH))
            last_idx = pli_pkg::IDX_W'(pli_pkg::TABLE_DEPTH - 1);
        else
            last_idx = pli_pkg::IDX_W'(count_reg - pli_pkg::COUNT_W'(1));
    end

    assign s_tready = !valid_reg || q_ready;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = valid_reg;
    assign q_req    = req_reg;

    always_comb
    begin
        req_next.op     = pli_pkg::op_t'(s_tuser[0]);
        req_next.index  = s_tdata[pli_pkg::IDX_LSB +: pli_pkg::IDX_W];
        req_next.radius = s_tdata[pli_pkg::RAD_LSB +: pli_pkg::RADIUS_W];
        req_next.value  = s_tdata[pli_pkg::VAL_LSB +: pli_pkg::VALUE_W];
        req_next.query  = s_tdata[pli_pkg::QRY_LSB +: pli_pkg::RADIUS_W];
        req_next.last   = last_idx;
    end

    always_comb
    begin
        priority if (accept)
            valid_next = 1'b1;
        else if (q_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= pli_pkg::COUNT_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_next;
        end
    end

endmodule

>>> hw/rtl/pli_queue.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator request queue
// Short register queue between the front end and the table engine.
// ----------------------------------------------------------------------------
module pli_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pli_pkg::req_t   push_req,
    output logic            ready,
    input  logic            pop,
    output logic            valid,
    output pli_pkg::req_t   head
);

    pli_pkg::req_t                slot_reg [pli_pkg::QUEUE_DEPTH];
    logic [pli_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [pli_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [pli_pkg::QPTR_W:0]     level_reg;
    logic [pli_pkg::QPTR_W:0]     level_next;
    logic                         do_push;
    logic                         do_pop;

    assign ready   = level_reg != (pli_pkg::QPTR_W+1)'(pli_pkg::QUEUE_DEPTH);
    assign valid   = level_reg != '0;
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_comb
    begin
        level_next = level_reg;
        if (do_push && !do_pop)
        begin
            level_next = level_reg + (pli_pkg::QPTR_W+1)'(1);
        end
        else if (!do_push && do_pop)
        begin
            level_next = level_reg - (pli_pkg::QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + pli_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + pli_pkg::QPTR_W'(1);
            end
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

>>> hw/rtl/pli_muldiv.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator multiply-divide unit
// Forms mag * offset in two partial products, then divides by width with a
// restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pli_muldiv (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  pli_pkg::md_req_t              req,
    output logic                          done,
    output logic [pli_pkg::MAG_W-1:0]     quo
);

    typedef enum logic [4:0] {
        MD_IDLE   = 5'b00001,
        MD_MUL_LO = 5'b00010,
        MD_MUL_HI = 5'b00100,
        MD_SUM    = 5'b01000,
        MD_DIV    = 5'b10000
    } md_state_t;

    md_state_t                          state_reg;
    md_state_t                          state_next;
    logic                               done_reg;
    logic                               done_next;
    logic [pli_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic [pli_pkg::DIV_CNT_W-1:0]      cnt_next;
    logic [pli_pkg::MAG_W-1:0]          mag_reg;
    logic [pli_pkg::RADIUS_W-1:0]       t_reg;
    logic [pli_pkg::RADIUS_W-1:0]       w_reg;
    logic [2*pli_pkg::RADIUS_W-1:0]     plo_reg;
    logic [2*pli_pkg::RADIUS_W-1:0]     plo_calc;
    logic [pli_pkg::HI_W+pli_pkg::RADIUS_W-1:0] phi_reg;
    logic [pli_pkg::HI_W+pli_pkg::RADIUS_W-1:0] phi_calc;
    logic [pli_pkg::PROD_W-1:0]         prod;
    logic [pli_pkg::RADIUS_W-1:0]       rem_reg;
    logic [pli_pkg::RADIUS_W-1:0]       rem_next;
    logic [pli_pkg::MAG_W-1:0]          acc_reg;
    logic [pli_pkg::MAG_W-1:0]          acc_next;
    logic [pli_pkg::RADIUS_W:0]         trial;
    logic [pli_pkg::RADIUS_W:0]         trial_diff;
    logic                               ge;

    assign plo_calc = mag_reg[pli_pkg::RADIUS_W-1:0] * t_reg;
    assign phi_calc = mag_reg[pli_pkg::MAG_W-1:pli_pkg::RADIUS_W] * t_reg;
    assign prod     = {phi_reg, {pli_pkg::RADIUS_W{1'b0}}}
                    + {{pli_pkg::HI_W{1'b0}}, plo_reg};

    assign trial      = {rem_reg, acc_reg[pli_pkg::MAG_W-1]};
    assign trial_diff = trial - {1'b0, w_reg};
    assign ge         = trial >= {1'b0, w_reg};

    assign done = done_reg;
    assign quo  = acc_reg;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        unique case (state_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    state_next = MD_MUL_LO;
                end
            end
            MD_MUL_LO:
            begin
                state_next = MD_MUL_HI;
            end
            MD_MUL_HI:
            begin
                state_next = MD_SUM;
            end
            MD_SUM:
            begin
                // quotient fits MAG_W bits, so the top bits start below width
                rem_next   = prod[pli_pkg::PROD_W-1:pli_pkg::MAG_W];
                acc_next   = prod[pli_pkg::MAG_W-1:0];
                cnt_next   = '0;
                state_next = MD_DIV;
            end
            MD_DIV:
            begin
                rem_next = ge ? trial_diff[pli_pkg::RADIUS_W-1:0]
                              : trial[pli_pkg::RADIUS_W-1:0];
                acc_next = {acc_reg[pli_pkg::MAG_W-2:0], ge};
                cnt_next = cnt_reg + pli_pkg::DIV_CNT_W'(1);
                if (cnt_reg == pli_pkg::DIV_CNT_W'(pli_pkg::MAG_W - 1))
                begin
                    done_next  = 1'b1;
                    state_next = MD_IDLE;
                end
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && state_reg == MD_IDLE)
        begin
            mag_reg <= req.mag;
            t_reg   <= req.offset;
            w_reg   <= req.width;
        end
        plo_reg <= plo_calc;
        phi_reg <= phi_calc;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        acc_reg <= acc_next;
    end

endmodule

>>> hw/rtl/pli_back.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator table engine
// Owns the breakpoint table, carries out writes and queries, scans segments
// one entry per cycle and holds the result register.
// ----------------------------------------------------------------------------
module pli_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  pli_pkg::req_t                     q_head,
    output logic                              q_pop,
    output logic                              md_start,
    output pli_pkg::md_req_t                  md_req,
    input  logic                              md_done,
    input  logic [pli_pkg::MAG_W-1:0]         md_quo,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pli_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [pli_pkg::STATUS_W-1:0]      m_tuser
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LAST  = 5'b00010,
        ST_FIRST = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_MATH  = 5'b10000
    } state_t;

    logic [pli_pkg::ENTRY_W-1:0]        table_mem [pli_pkg::TABLE_DEPTH];
    logic [pli_pkg::ENTRY_W-1:0]        rdata_reg;
    logic [pli_pkg::IDX_W-1:0]          rd_addr;
    logic                               tbl_we;

    state_t                             state_reg;
    state_t                             state_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic signed [pli_pkg::VALUE_W-1:0] out_value_reg;
    logic signed [pli_pkg::VALUE_W-1:0] out_value_next;
    pli_pkg::status_t                   out_status_reg;
    pli_pkg::status_t                   out_status_next;
    logic [pli_pkg::RADIUS_W-1:0]       query_reg;
    logic [pli_pkg::RADIUS_W-1:0]       query_next;
    logic [pli_pkg::IDX_W-1:0]          last_reg;
    logic [pli_pkg::IDX_W-1:0]          last_next;
    logic [pli_pkg::RADIUS_W-1:0]       last_r_reg;
    logic [pli_pkg::RADIUS_W-1:0]       last_r_next;
    logic [pli_pkg::IDX_W-1:0]          idx_reg;
    logic [pli_pkg::IDX_W-1:0]          idx_next;
    logic [pli_pkg::RADIUS_W-1:0]       prev_r_reg;
    logic [pli_pkg::RADIUS_W-1:0]       prev_r_next;
    logic signed [pli_pkg::VALUE_W-1:0] prev_v_reg;
    logic signed [pli_pkg::VALUE_W-1:0] prev_v_next;
    logic signed [pli_pkg::VALUE_W-1:0] base_reg;
    logic signed [pli_pkg::VALUE_W-1:0] base_next;
    logic                               neg_reg;
    logic                               neg_next;

    logic                               out_free;
    logic                               take;
    logic [pli_pkg::RADIUS_W-1:0]       cur_r;
    logic signed [pli_pkg::VALUE_W-1:0] cur_v;
    logic                               hit;
    logic [pli_pkg::MAG_W-1:0]          diff;
    logic                               diff_neg;
    logic [pli_pkg::RADIUS_W-1:0]       seg_width;
    logic [pli_pkg::MAG_W-1:0]          math_sum;

    assign out_free = !out_valid_reg || m_tready;
    assign take     = (state_reg == ST_IDLE) && q_valid && out_free;
    assign q_pop    = take;
    assign tbl_we   = take && (q_head.op == pli_pkg::OP_WRITE);

    assign cur_r = rdata_reg[pli_pkg::RADIUS_W-1:0];
    assign cur_v = rdata_reg[pli_pkg::ENTRY_W-1:pli_pkg::RADIUS_W];
    assign hit   = (prev_r_reg <= query_reg) && (query_reg <= cur_r);

    assign diff      = {cur_v[pli_pkg::VALUE_W-1], cur_v}
                     - {prev_v_reg[pli_pkg::VALUE_W-1], prev_v_reg};
    assign diff_neg  = diff[pli_pkg::MAG_W-1];
    assign seg_width = cur_r - prev_r_reg;

    assign md_req.mag    = diff_neg ? (~diff + pli_pkg::MAG_W'(1)) : diff;
    assign md_req.offset = query_reg - prev_r_reg;
    assign md_req.width  = seg_width;

    assign math_sum = neg_reg ? ({base_reg[pli_pkg::VALUE_W-1], base_reg} - md_quo)
                              : ({base_reg[pli_pkg::VALUE_W-1], base_reg} + md_quo);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = pli_pkg::OUT_DATA_W'(out_value_reg);
    assign m_tuser  = out_status_reg;

    // the table data register holds the entry addressed in the cycle before
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:  rd_addr = q_head.last;
            ST_LAST:  rd_addr = '0;
            ST_FIRST: rd_addr = pli_pkg::IDX_W'(1);
            ST_SCAN:  rd_addr = idx_reg + pli_pkg::IDX_W'(1);
            ST_MATH:  rd_addr = idx_reg;
            default:  rd_addr = idx_reg;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        query_next      = query_reg;
        last_next       = last_reg;
        last_r_next     = last_r_reg;
        idx_next        = idx_reg;
        prev_r_next     = prev_r_reg;
        prev_v_next     = prev_v_reg;
        base_next       = base_reg;
        neg_next        = neg_reg;
        md_start        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (q_head.op == pli_pkg::OP_WRITE)
                    begin
                        out_valid_next  = 1'b1;
                        out_value_next  = '0;
                        out_status_next = pli_pkg::STATUS_OK;
                    end
                    else
                    begin
                        query_next = q_head.query;
                        last_next  = q_head.last;
                        state_next = ST_LAST;
                    end
                end
            end
            ST_LAST:
            begin
                last_r_next = cur_r;
                state_next  = ST_FIRST;
            end
            ST_FIRST:
            begin
                if (query_reg < cur_r || query_reg > last_r_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_status_next = pli_pkg::STATUS_RANGE;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    prev_r_next = cur_r;
                    prev_v_next = cur_v;
                    idx_next    = pli_pkg::IDX_W'(1);
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                priority if (hit && seg_width == '0)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = prev_v_reg;
                    out_status_next = pli_pkg::STATUS_OK;
                    state_next      = ST_IDLE;
                end
                else if (hit)
                begin
                    md_start   = 1'b1;
                    base_next  = prev_v_reg;
                    neg_next   = diff_neg;
                    state_next = ST_MATH;
                end
                else if (idx_reg == last_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_status_next = pli_pkg::STATUS_NOSEG;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    prev_r_next = cur_r;
                    prev_v_next = cur_v;
                    idx_next    = idx_reg + pli_pkg::IDX_W'(1);
                end
            end
            ST_MATH:
            begin
                if (md_done)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = math_sum[pli_pkg::VALUE_W-1:0];
                    out_status_next = pli_pkg::STATUS_OK;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        query_reg      <= query_next;
        last_reg       <= last_next;
        last_r_reg     <= last_r_next;
        idx_reg        <= idx_next;
        prev_r_reg     <= prev_r_next;
        prev_v_reg     <= prev_v_next;
        base_reg       <= base_next;
        neg_reg        <= neg_next;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            table_mem[q_head.index] <= {q_head.value, q_head.radius};
        end
        rdata_reg <= table_mem[rd_addr];
    end

endmodule
